### rtl/core/slpc_pkg.sv
// ----------------------------------------------------------------------------
// slpc_pkg
// Shared types and constants of the slave link poll controller.
// ----------------------------------------------------------------------------
`default_nettype none

package slpc_pkg;

  // Field widths of the word formats.
  localparam int unsigned ActionW = 2;
  localparam int unsigned WordW   = 16;
  localparam int unsigned SlotW   = 5;
  localparam int unsigned BitW    = 4;
  localparam int unsigned LevelW  = 5;
  localparam int unsigned CfgIdxW = 3;

  // Default sizing.
  localparam int unsigned QueueLenDefault  = 21;
  localparam int unsigned FailLimitDefault = 16;

  // Register reset values.
  localparam logic [WordW-1:0] IdCodeRst     = 16'd0;
  localparam logic [BitW-1:0]  ReadyBitRst   = 4'd0;
  localparam logic [SlotW-1:0] EnableSlotRst = 5'd3;
  localparam logic [BitW-1:0]  EnableBitRst  = 4'd0;
  localparam logic [WordW-1:0] HalfPeriodRst = 16'd500;

  localparam logic [WordW-1:0] TickMax = 16'hFFFF;

  typedef enum logic [CfgIdxW-1:0] {
    CfgIdCode     = 3'd0,
    CfgReadyBit   = 3'd1,
    CfgEnableSlot = 3'd2,
    CfgEnableBit  = 3'd3,
    CfgHalfPeriod = 3'd4
  } cfg_idx_e;

  typedef enum logic [ActionW-1:0] {
    ActPoll  = 2'd0,
    ActStart = 2'd1,
    ActTick  = 2'd2,
    ActRead  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    PhId    = 2'd0,
    PhWait  = 2'd1,
    PhReady = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ReqId     = 2'd0,
    ReqStatus = 2'd1,
    ReqSlot   = 2'd2,
    ReqNone   = 2'd3
  } req_e;

  // One result word.
  typedef struct packed {
    logic [1:0]        next_request;
    logic [SlotW-1:0]  next_slot;
    logic              reload_strobe;
    logic [1:0]        link_phase;
    logic              capture_done;
    logic              link_fault;
    logic [LevelW-1:0] fail_level;
    logic [WordW-1:0]  slot_value;
  } result_t;

  // Store write request from the update logic.
  typedef struct packed {
    logic             we;
    logic [SlotW-1:0] slot;
    logic [WordW-1:0] data;
  } store_wr_t;

endpackage

`default_nettype wire

### rtl/core/slave_link_poll_controller.sv
// ----------------------------------------------------------------------------
// slave_link_poll_controller
// Poll supervisor for a slave link: identity, readiness, register capture.
// ----------------------------------------------------------------------------
// The controller takes one word per clock cycle while the output side is not
// stalled and gives one result word per input word, through the update stage
// registers and then the output register. In the accept cycle the register
// store is read (the slot named by query_slot for a read action, otherwise the
// enable slot); the update logic then applies the word and writes the store
// back when the update stage advances. The RAM read is registered; a write
// that hits the entry being read by the following word is forwarded, so
// back-to-back words see each other's writes. The store reads as all zero
// after reset through a row of valid bits, so no clearing pass is needed and
// words are taken from the first cycle after reset. Configuration is written
// through a plain write port and must only change while the block is idle.
`default_nettype none

module slave_link_poll_controller #(
  parameter int unsigned QueueLen  = slpc_pkg::QueueLenDefault,
  parameter int unsigned FailLimit = slpc_pkg::FailLimitDefault
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration write port.
  input  wire logic                             cfg_we_i,
  input  wire logic [slpc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [slpc_pkg::WordW-1:0]       cfg_wdata_i,
  // Input channel.
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [slpc_pkg::ActionW-1:0]     action_i,
  input  wire logic [slpc_pkg::WordW-1:0]       read_data_i,
  input  wire logic                             checksum_good_i,
  input  wire logic [slpc_pkg::SlotW-1:0]       query_slot_i,
  // Output channel.
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [1:0]                            next_request_o,
  output logic [slpc_pkg::SlotW-1:0]            next_slot_o,
  output logic                                  reload_strobe_o,
  output logic [1:0]                            link_phase_o,
  output logic                                  capture_done_o,
  output logic                                  link_fault_o,
  output logic [slpc_pkg::LevelW-1:0]           fail_level_o,
  output logic [slpc_pkg::WordW-1:0]            slot_value_o
);

  localparam int unsigned AW = (QueueLen > 1) ? $clog2(QueueLen) : 1;
  localparam logic [slpc_pkg::SlotW:0] QLenExt = (slpc_pkg::SlotW + 1)'(QueueLen);

  // Configuration registers.
  logic [slpc_pkg::WordW-1:0] id_code_q;
  logic [slpc_pkg::BitW-1:0]  ready_bit_q;
  logic [slpc_pkg::SlotW-1:0] enable_slot_q;
  logic [slpc_pkg::BitW-1:0]  enable_bit_q;
  logic [slpc_pkg::WordW-1:0] half_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_code_q     <= slpc_pkg::IdCodeRst;
      ready_bit_q   <= slpc_pkg::ReadyBitRst;
      enable_slot_q <= slpc_pkg::EnableSlotRst;
      enable_bit_q  <= slpc_pkg::EnableBitRst;
      half_period_q <= slpc_pkg::HalfPeriodRst;
    end else if (cfg_we_i) begin
      case (slpc_pkg::cfg_idx_e'(cfg_idx_i))
        slpc_pkg::CfgIdCode:     id_code_q     <= cfg_wdata_i;
        slpc_pkg::CfgReadyBit:   ready_bit_q   <= cfg_wdata_i[slpc_pkg::BitW-1:0];
        slpc_pkg::CfgEnableSlot: enable_slot_q <= cfg_wdata_i[slpc_pkg::SlotW-1:0];
        slpc_pkg::CfgEnableBit:  enable_bit_q  <= cfg_wdata_i[slpc_pkg::BitW-1:0];
        slpc_pkg::CfgHalfPeriod: half_period_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake: the update stage advances when the output register is free or
  // being emptied; a new word enters whenever the update stage is empty or advances.
  logic s1_valid_q;
  logic s1_adv;
  logic in_acc;

  assign s1_adv     = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // Store read issued in the accept cycle.
  logic [slpc_pkg::SlotW-1:0] rd_slot;
  logic                       rd_inrange;
  logic [AW-1:0]              rd_addr;

  assign rd_slot    = (slpc_pkg::action_e'(action_i) == slpc_pkg::ActRead)
                      ? query_slot_i : enable_slot_q;
  assign rd_inrange = ({1'b0, rd_slot} < QLenExt);
  assign rd_addr    = rd_slot[AW-1:0];

  // Update stage registers.
  slpc_pkg::action_e          s1_action_q;
  logic [slpc_pkg::WordW-1:0] s1_data_q;
  logic                       s1_good_q;
  logic                       s1_hit_q;
  logic                       s1_fwd_q;
  logic [slpc_pkg::WordW-1:0] s1_fwd_data_q;

  slpc_pkg::store_wr_t        wr;
  slpc_pkg::result_t          res;
  logic [slpc_pkg::WordW-1:0] ram_rdata;
  logic [slpc_pkg::WordW-1:0] rd_word;
  logic [QueueLen-1:0]        vld_q;
  logic                       fwd_hit;

  assign fwd_hit = wr.we && (wr.slot == rd_slot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_action_q   <= slpc_pkg::action_e'(action_i);
      s1_data_q     <= read_data_i;
      s1_good_q     <= checksum_good_i;
      // An out-of-range slot and a never-written entry both read as zero.
      s1_hit_q      <= rd_inrange && vld_q[rd_addr];
      s1_fwd_q      <= rd_inrange && fwd_hit;
      s1_fwd_data_q <= wr.data;
    end
  end

  // Valid bits stand in for clearing the store at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr.we) begin
      vld_q[wr.slot[AW-1:0]] <= 1'b1;
    end
  end

  slpc_ram #(
    .Width (slpc_pkg::WordW),
    .Depth (QueueLen)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.slot[AW-1:0]),
    .wdata_i (wr.data),
    .re_i    (in_acc && rd_inrange),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (s1_fwd_q) begin
      rd_word = s1_fwd_data_q;
    end else if (s1_hit_q) begin
      rd_word = ram_rdata;
    end else begin
      rd_word = '0;
    end
  end

  slpc_ctrl #(
    .QueueLen  (QueueLen),
    .FailLimit (FailLimit)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (s1_adv),
    .action_i        (s1_action_q),
    .read_data_i     (s1_data_q),
    .checksum_good_i (s1_good_q),
    .rd_word_i       (rd_word),
    .id_code_i       (id_code_q),
    .ready_bit_i     (ready_bit_q),
    .enable_bit_i    (enable_bit_q),
    .half_period_i   (half_period_q),
    .result_o        (res),
    .wr_o            (wr)
  );

  // Output register.
  slpc_pkg::result_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s1_adv) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= res;
    end
  end

  assign next_request_o  = out_q.next_request;
  assign next_slot_o     = out_q.next_slot;
  assign reload_strobe_o = out_q.reload_strobe;
  assign link_phase_o    = out_q.link_phase;
  assign capture_done_o  = out_q.capture_done;
  assign link_fault_o    = out_q.link_fault;
  assign fail_level_o    = out_q.fail_level;
  assign slot_value_o    = out_q.slot_value;

  // Store writes stay inside the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.we |-> ({1'b0, wr.slot} < QLenExt))
    else $error("store write outside the queue");

  // A word held in the update stage is not dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> s1_valid_q)
    else $error("update stage lost a word");

  // Writes only happen when a word is applied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.we |-> s1_adv)
    else $error("store write without an applied word");

  // A slot request implies a capture pass is still pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && next_request_o == slpc_pkg::ReqSlot) |-> !capture_done_o)
    else $error("slot requested with no capture pending");

  // The link phase never takes the unused code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (link_phase_o != 2'd3))
    else $error("invalid link phase");

endmodule

`default_nettype wire

### rtl/core/slpc_ram.sv
// ----------------------------------------------------------------------------
// slpc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module slpc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 21,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/slpc_ctrl.sv
// ----------------------------------------------------------------------------
// slpc_ctrl
// Link state, failure counter and watchdog timer; one word is applied per step.
// ----------------------------------------------------------------------------
`default_nettype none

module slpc_ctrl #(
  parameter int unsigned QueueLen  = slpc_pkg::QueueLenDefault,
  parameter int unsigned FailLimit = slpc_pkg::FailLimitDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            step_i,
  input  wire slpc_pkg::action_e               action_i,
  input  wire logic [slpc_pkg::WordW-1:0]      read_data_i,
  input  wire logic                            checksum_good_i,
  input  wire logic [slpc_pkg::WordW-1:0]      rd_word_i,
  input  wire logic [slpc_pkg::WordW-1:0]      id_code_i,
  input  wire logic [slpc_pkg::BitW-1:0]       ready_bit_i,
  input  wire logic [slpc_pkg::BitW-1:0]       enable_bit_i,
  input  wire logic [slpc_pkg::WordW-1:0]      half_period_i,
  output slpc_pkg::result_t                    result_o,
  output slpc_pkg::store_wr_t                  wr_o
);

  localparam int unsigned FW  = $clog2(FailLimit + 1);
  localparam int unsigned FW1 = FW + 1;
  localparam logic [FW1-1:0] LimitExt = FW1'(FailLimit);
  localparam logic [FW-1:0]  LimitVal = FW'(FailLimit);
  localparam logic [slpc_pkg::SlotW:0] QLenExt = (slpc_pkg::SlotW + 1)'(QueueLen);

  slpc_pkg::phase_e                phase_q, phase_d;
  logic                            capturing_q, capturing_d;
  logic [slpc_pkg::SlotW-1:0]      qpos_q, qpos_d;
  logic [FW-1:0]                   fail_q, fail_d;
  logic                            fault_q, fault_d;
  logic [slpc_pkg::WordW-1:0]      since_q, since_d;

  logic                            enabled;
  logic [FW1-1:0]                  fail_inc;
  logic [slpc_pkg::SlotW:0]        qpos_inc;
  logic [31:0]                     fail_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= slpc_pkg::PhId;
      capturing_q <= 1'b1;
      qpos_q      <= '0;
      fail_q      <= '0;
      fault_q     <= 1'b0;
      since_q     <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      capturing_q <= capturing_d;
      qpos_q      <= qpos_d;
      fail_q      <= fail_d;
      fault_q     <= fault_d;
      since_q     <= since_d;
    end
  end

  assign enabled  = rd_word_i[enable_bit_i];
  assign fail_inc = {1'b0, fail_q} + FW1'(1);
  assign qpos_inc = {1'b0, qpos_q} + (slpc_pkg::SlotW + 1)'(1);
  assign fail_ext = 32'(fail_d);

  always_comb begin
    phase_d     = phase_q;
    capturing_d = capturing_q;
    qpos_d      = qpos_q;
    fail_d      = fail_q;
    fault_d     = fault_q;
    since_d     = since_q;
    wr_o        = '0;
    result_o    = '0;

    case (action_i)
      slpc_pkg::ActPoll: begin
        case (phase_q)
          slpc_pkg::PhId: begin
            if (read_data_i == id_code_i && checksum_good_i) begin
              phase_d = slpc_pkg::PhWait;
            end
          end
          slpc_pkg::PhWait: begin
            // The status word lands in slot 0 whatever its checksum.
            wr_o.we   = 1'b1;
            wr_o.slot = '0;
            wr_o.data = read_data_i;
            if (checksum_good_i && read_data_i[ready_bit_i]) begin
              phase_d = slpc_pkg::PhReady;
            end
          end
          default: begin
            if (enabled && since_q >= half_period_i) begin
              result_o.reload_strobe = 1'b1;
              since_d = '0;
            end
            if (capturing_q) begin
              if (checksum_good_i) begin
                if ({1'b0, qpos_q} < QLenExt) begin
                  wr_o.we   = 1'b1;
                  wr_o.slot = qpos_q;
                  wr_o.data = read_data_i;
                end
                if (fail_q != '0) begin
                  fail_d  = fail_q - FW'(1);
                  fault_d = 1'b0;
                end
              end else if (!fault_q) begin
                if (fail_inc >= LimitExt) begin
                  fail_d  = LimitVal;
                  fault_d = 1'b1;
                  phase_d = slpc_pkg::PhId;
                end else begin
                  fail_d = fail_inc[FW-1:0];
                end
              end
              if (qpos_inc >= QLenExt) begin
                qpos_d      = '0;
                capturing_d = 1'b0;
              end else begin
                qpos_d = qpos_inc[slpc_pkg::SlotW-1:0];
              end
            end
          end
        endcase
      end
      slpc_pkg::ActStart: begin
        capturing_d = 1'b1;
      end
      slpc_pkg::ActTick: begin
        if (since_q != slpc_pkg::TickMax) begin
          since_d = since_q + slpc_pkg::WordW'(1);
        end
      end
      default: begin
        result_o.slot_value = rd_word_i;
      end
    endcase

    wr_o.we = wr_o.we & step_i;

    case (phase_d)
      slpc_pkg::PhId:   result_o.next_request = slpc_pkg::ReqId;
      slpc_pkg::PhWait: result_o.next_request = slpc_pkg::ReqStatus;
      default: begin
        if (capturing_d) begin
          result_o.next_request = slpc_pkg::ReqSlot;
          result_o.next_slot    = qpos_d;
        end else begin
          result_o.next_request = slpc_pkg::ReqNone;
        end
      end
    endcase
    result_o.link_phase   = phase_d;
    result_o.capture_done = !capturing_d;
    result_o.link_fault   = fault_d;
    result_o.fail_level   = fail_ext[slpc_pkg::LevelW-1:0];
  end

endmodule

`default_nettype wire
